// ===== rtl/path_waypoint_search_core_macros.svh =====
// assertion helpers for the path_waypoint_search_core rtl file
`ifndef PATH_WAYPOINT_SEARCH_CORE_MACROS_SVH
`define PATH_WAYPOINT_SEARCH_CORE_MACROS_SVH

// same-cycle implication, held off during reset
`define PWS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pws check failed");

// next-cycle implication, held off during reset
`define PWS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pws check failed");

`endif

// ===== rtl/pws_pkg.sv =====
`default_nettype none
package pws_pkg;

    localparam int MAX_POINTS_DEF = 256;
    localparam int COORD_BITS_DEF = 16;
    localparam int LA_BITS        = 15;
    localparam int LA_SQ_BITS     = 2 * LA_BITS;
    localparam logic [7:0] MARGIN_RESET = 8'd5;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_FIN
    } t_state;

    // per-cell control: rotate from neighbor or load an appended point
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage
`default_nettype wire

// ===== rtl/pws_cell.sv =====
`default_nettype none
module pws_cell #(
    parameter int COORD_BITS = pws_pkg::COORD_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire pws_pkg::t_cell_ctl      i_ctl,
    input  wire logic signed [COORD_BITS-1:0] i_shift_x,
    input  wire logic signed [COORD_BITS-1:0] i_shift_y,
    input  wire logic signed [COORD_BITS-1:0] i_load_x,
    input  wire logic signed [COORD_BITS-1:0] i_load_y,
    output logic signed [COORD_BITS-1:0] o_x,
    output logic signed [COORD_BITS-1:0] o_y
);

    logic signed [COORD_BITS-1:0] r_x, r_y;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_x <= i_shift_x;
            r_y <= i_shift_y;
        end else if (i_ctl.load) begin
            r_x <= i_load_x;
            r_y <= i_load_y;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule
`default_nettype wire

// ===== rtl/pws_dist.sv =====
`default_nettype none
module pws_dist #(
    parameter int COORD_BITS = pws_pkg::COORD_BITS_DEF,
    parameter int IDX_BITS   = 8
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    input  wire logic [IDX_BITS-1:0]     i_idx,
    input  wire logic signed [COORD_BITS-1:0] i_way_x,
    input  wire logic signed [COORD_BITS-1:0] i_way_y,
    input  wire logic signed [COORD_BITS-1:0] i_rob_x,
    input  wire logic signed [COORD_BITS-1:0] i_rob_y,
    output logic                         o_valid,
    output logic [IDX_BITS-1:0]          o_idx,
    output logic signed [COORD_BITS-1:0] o_x,
    output logic signed [COORD_BITS-1:0] o_y,
    output logic [2*COORD_BITS:0]        o_dist,
    output logic                         o_busy
);

    localparam int C = COORD_BITS;

    logic [2:0] r_v;
    logic [IDX_BITS-1:0] r_idx [3];
    logic signed [C-1:0] r_x [3];
    logic signed [C-1:0] r_y [3];
    logic signed [C:0] r_dx, r_dy;
    logic [2*C-1:0] r_sqx, r_sqy;
    logic [2*C:0] r_sum;
    logic signed [2*C+1:0] px, py;

    assign px = r_dx * r_dx;
    assign py = r_dy * r_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        // stage 1: differences
        r_dx     <= (C+1)'(i_rob_x) - (C+1)'(i_way_x);
        r_dy     <= (C+1)'(i_rob_y) - (C+1)'(i_way_y);
        r_idx[0] <= i_idx;
        r_x[0]   <= i_way_x;
        r_y[0]   <= i_way_y;
        // stage 2: squares
        r_sqx    <= px[2*C-1:0];
        r_sqy    <= py[2*C-1:0];
        r_idx[1] <= r_idx[0];
        r_x[1]   <= r_x[0];
        r_y[1]   <= r_y[0];
        // stage 3: sum
        r_sum    <= (2*C+1)'(r_sqx) + (2*C+1)'(r_sqy);
        r_idx[2] <= r_idx[1];
        r_x[2]   <= r_x[1];
        r_y[2]   <= r_y[1];
    end

    assign o_valid = r_v[2];
    assign o_idx   = r_idx[2];
    assign o_x     = r_x[2];
    assign o_y     = r_y[2];
    assign o_dist  = r_sum;
    assign o_busy  = |r_v;

endmodule
`default_nettype wire

// ===== rtl/path_waypoint_search_core.sv =====
// path waypoint search core: clear, append and query words on one channel
// clear, append and unused codes: result word registered in the cycle after accept
// query: result set by one full rotation of the waypoint
//   cell ring past a single 3-stage distance unit; one word in flight at a time
// synchronous active-low reset empties the path and sets the margin to 5;
//   waypoint cells hold no reset value and are only read once appended
`default_nettype none
module path_waypoint_search_core #(
    parameter int MAX_POINTS = pws_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = pws_pkg::COORD_BITS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    // request channel
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  wire logic [1:0]   i_req_type,
    input  wire logic signed [15:0] i_coord_x,
    input  wire logic signed [15:0] i_coord_y,
    input  wire logic [7:0]   i_query_index,
    input  wire logic [14:0]  i_lookahead_dist,
    // result channel
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output logic [1:0]        o_status,
    output logic [7:0]        o_closest_index,
    output logic signed [15:0] o_closest_x,
    output logic signed [15:0] o_closest_y,
    output logic [7:0]        o_ahead_index,
    output logic signed [15:0] o_ahead_x,
    output logic signed [15:0] o_ahead_y,
    output logic signed [15:0] o_point_x,
    output logic signed [15:0] o_point_y,
    output logic              o_near_end,
    // margin register write channel
    input  wire               i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [7:0]   i_cfg_data
);

    localparam int C    = COORD_BITS;
    localparam int IW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NW   = $clog2(MAX_POINTS + 1);
    localparam int DW   = 2 * C + 1;
    localparam int CW   = (DW > pws_pkg::LA_SQ_BITS) ? DW : pws_pkg::LA_SQ_BITS;

    // ---------------- control state
    pws_pkg::t_state r_state, n_state;
    logic [NW-1:0]   r_count;
    logic [NW-1:0]   r_t;          // rotation step, head cell holds waypoint r_t
    logic [7:0]      r_margin;
    logic            r_out_valid;

    // ---------------- query context
    logic signed [C-1:0] r_rob_x, r_rob_y;
    logic [7:0]          r_qi;
    logic [pws_pkg::LA_SQ_BITS-1:0] r_la_sq;
    logic [IW-1:0]       r_pt, r_last;
    logic                r_near;

    // ---------------- tracking registers
    logic [DW-1:0]       r_best_d;
    logic [IW-1:0]       r_best_idx, r_ahead_idx;
    logic signed [C-1:0] r_best_x, r_best_y, r_ahead_x, r_ahead_y;
    logic signed [C-1:0] r_last_x, r_last_y, r_pt_x, r_pt_y;
    logic                r_found;

    // ---------------- output word
    logic [1:0]          r_status;
    logic [7:0]          r_cl_idx, r_ah_idx;
    logic signed [15:0]  r_cl_x, r_cl_y, r_ah_x, r_ah_y, r_pt_ox, r_pt_oy;
    logic                r_near_o;

    // cell ring
    logic signed [C-1:0] cell_x [MAX_POINTS];
    logic signed [C-1:0] cell_y [MAX_POINTS];
    logic signed [C-1:0] in_x, in_y;

    // distance unit
    logic          d_valid, d_busy;
    logic [IW-1:0] d_idx;
    logic signed [C-1:0] d_x, d_y;
    logic [DW-1:0] d_dist;

    logic in_acc, out_free, sweeping, finish;
    logic [IW-1:0] pt_next, last_next;
    logic near_next;
    pws_pkg::t_req req;

    assign req      = pws_pkg::t_req'(i_req_type);
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == pws_pkg::ST_IDLE) && out_free);
    assign in_acc   = i_in_valid && !o_in_stall;
    assign sweeping = (r_state == pws_pkg::ST_SWEEP);
    assign finish   = (r_state == pws_pkg::ST_FIN) && out_free;
    assign o_cfg_ready = 1'b1;

    // input coordinates wrapped to the internal width
    assign in_x = C'(i_coord_x);
    assign in_y = C'(i_coord_y);

    // query-time index math
    always_comb begin
        last_next = IW'(r_count - NW'(1));
        pt_next   = (32'(i_query_index) > 32'(last_next)) ? last_next : IW'(i_query_index);
        near_next = (int'(last_next) - int'(i_query_index)) <= int'(r_margin);
    end

    // ---------------- ring of waypoint cells
    for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
        pws_pkg::t_cell_ctl ctl;
        assign ctl.shift = sweeping;
        assign ctl.load  = in_acc && (req == pws_pkg::REQ_APPEND) &&
                           (32'(r_count) == k);
        pws_cell #(.COORD_BITS(C)) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (ctl),
            .i_shift_x (cell_x[(k + 1) % MAX_POINTS]),
            .i_shift_y (cell_y[(k + 1) % MAX_POINTS]),
            .i_load_x  (in_x),
            .i_load_y  (in_y),
            .o_x       (cell_x[k]),
            .o_y       (cell_y[k])
        );
    end

    pws_dist #(.COORD_BITS(C), .IDX_BITS(IW)) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sweeping && (r_t < r_count)),
        .i_idx   (IW'(r_t)),
        .i_way_x (cell_x[0]),
        .i_way_y (cell_y[0]),
        .i_rob_x (r_rob_x),
        .i_rob_y (r_rob_y),
        .o_valid (d_valid),
        .o_idx   (d_idx),
        .o_x     (d_x),
        .o_y     (d_y),
        .o_dist  (d_dist),
        .o_busy  (d_busy)
    );

    // ---------------- next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pws_pkg::ST_IDLE: begin
                if (in_acc && (req == pws_pkg::REQ_QUERY) && (r_count != '0)) begin
                    n_state = pws_pkg::ST_SWEEP;
                end
            end
            pws_pkg::ST_SWEEP: begin
                if (r_t == NW'(MAX_POINTS - 1)) begin
                    n_state = pws_pkg::ST_DRAIN;
                end
            end
            pws_pkg::ST_DRAIN: begin
                if (!d_busy) begin
                    n_state = pws_pkg::ST_FIN;
                end
            end
            pws_pkg::ST_FIN: begin
                if (out_free) begin
                    n_state = pws_pkg::ST_IDLE;
                end
            end
            default: n_state = pws_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pws_pkg::ST_IDLE;
            r_count     <= '0;
            r_margin    <= pws_pkg::MARGIN_RESET;
            r_out_valid <= 1'b0;
            r_t         <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_margin <= i_cfg_data;
            end
            if (in_acc && (req == pws_pkg::REQ_CLEAR)) begin
                r_count <= '0;
            end else if (in_acc && (req == pws_pkg::REQ_APPEND) &&
                         (r_count < NW'(MAX_POINTS))) begin
                r_count <= r_count + NW'(1);
            end
            // rotation counter
            if (sweeping) begin
                r_t <= r_t + NW'(1);
            end else begin
                r_t <= '0;
            end
            // result word: loaded directly for short requests and empty queries, at finish for other queries
            if ((in_acc && !((req == pws_pkg::REQ_QUERY) && (r_count != '0))) || finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- query context and tracking
    always_ff @(posedge i_clk) begin
        if (in_acc && (req == pws_pkg::REQ_QUERY)) begin
            r_rob_x <= in_x;
            r_rob_y <= in_y;
            r_qi    <= i_query_index;
            r_la_sq <= pws_pkg::LA_SQ_BITS'(i_lookahead_dist) *
                       pws_pkg::LA_SQ_BITS'(i_lookahead_dist);
            r_pt    <= pt_next;
            r_last  <= last_next;
            r_near  <= near_next;
            r_found <= 1'b0;
        end
        // point at clamped index, taken straight from the ring head
        if (sweeping && (r_t < r_count) && (IW'(r_t) == r_pt)) begin
            r_pt_x <= cell_x[0];
            r_pt_y <= cell_y[0];
        end
        if (d_valid) begin
            // nearest, first index wins ties
            if ((d_idx == '0) || (d_dist < r_best_d)) begin
                r_best_d   <= d_dist;
                r_best_idx <= d_idx;
                r_best_x   <= d_x;
                r_best_y   <= d_y;
            end
            // first waypoint at or past the start whose distance reaches lookahead
            if (!r_found && (32'(d_idx) >= 32'(r_qi)) &&
                (CW'(d_dist) >= CW'(r_la_sq))) begin
                r_found     <= 1'b1;
                r_ahead_idx <= d_idx;
                r_ahead_x   <= d_x;
                r_ahead_y   <= d_y;
            end
            if (d_idx == r_last) begin
                r_last_x <= d_x;
                r_last_y <= d_y;
            end
        end
    end

    // ---------------- result word register
    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_status <= pws_pkg::STAT_OK;
            r_cl_idx <= 8'(r_best_idx);
            r_cl_x   <= 16'(32'(r_best_x));
            r_cl_y   <= 16'(32'(r_best_y));
            if (r_found) begin
                r_ah_idx <= 8'(r_ahead_idx);
                r_ah_x   <= 16'(32'(r_ahead_x));
                r_ah_y   <= 16'(32'(r_ahead_y));
            end else begin
                r_ah_idx <= 8'(r_last);
                r_ah_x   <= 16'(32'(r_last_x));
                r_ah_y   <= 16'(32'(r_last_y));
            end
            r_pt_ox  <= 16'(32'(r_pt_x));
            r_pt_oy  <= 16'(32'(r_pt_y));
            r_near_o <= r_near;
        end else if (in_acc) begin
            // short requests and empty queries carry only a status
            r_cl_idx <= '0;
            r_cl_x   <= '0;
            r_cl_y   <= '0;
            r_ah_idx <= '0;
            r_ah_x   <= '0;
            r_ah_y   <= '0;
            r_pt_ox  <= '0;
            r_pt_oy  <= '0;
            r_near_o <= 1'b0;
            if ((req == pws_pkg::REQ_APPEND) && (r_count >= NW'(MAX_POINTS))) begin
                r_status <= pws_pkg::STAT_FULL;
            end else if ((req == pws_pkg::REQ_QUERY) && (r_count == '0)) begin
                r_status <= pws_pkg::STAT_EMPTY;
            end else begin
                r_status <= pws_pkg::STAT_OK;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_closest_index = r_cl_idx;
    assign o_closest_x     = r_cl_x;
    assign o_closest_y     = r_cl_y;
    assign o_ahead_index   = r_ah_idx;
    assign o_ahead_x       = r_ah_x;
    assign o_ahead_y       = r_ah_y;
    assign o_point_x       = r_pt_ox;
    assign o_point_y       = r_pt_oy;
    assign o_near_end      = r_near_o;

    // ---------------- checks
    `include "path_waypoint_search_core_macros.svh"

    // words are taken only between queries
    `PWS_ASSERT_IMP(a_accept_idle, i_clk, i_rst_n, in_acc, r_state == pws_pkg::ST_IDLE)
    // path length never exceeds the ring
    `PWS_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= NW'(MAX_POINTS))
    // distance pipe is empty once a query has finished
    `PWS_ASSERT_IMP(a_pipe_empty, i_clk, i_rst_n, r_state == pws_pkg::ST_IDLE, !d_busy)
    // a finished query always presents a result word next
    `PWS_ASSERT_NXT(a_fin_out, i_clk, i_rst_n, finish, o_out_valid)

endmodule
`default_nettype wire
